// ----- src/frts_pkg.sv -----
// package for the fragment reassembler with time-code queue
// constants, mode and status codes, and the item structs
// no dependencies
package frts_pkg;

  localparam int unsigned MaxPacket = 4096;
  localparam int unsigned TcDepth   = 8;
  localparam int unsigned StoreAw   = $clog2(MaxPacket);
  localparam int unsigned TcAw      = $clog2(TcDepth);
  localparam int unsigned SizeW     = StoreAw + 1;
  localparam int unsigned CntW      = TcAw + 1;

  localparam logic [2:0] MODE_HEADER  = 3'd0;
  localparam logic [2:0] MODE_PAYLOAD = 3'd1;
  localparam logic [2:0] MODE_READ    = 3'd2;
  localparam logic [2:0] MODE_RELEASE = 3'd3;
  localparam logic [2:0] MODE_POP     = 3'd4;
  localparam logic [2:0] MODE_RESET   = 3'd5;

  localparam logic [1:0] KIND_LINK = 2'd0;
  localparam logic [1:0] KIND_TC   = 2'd1;
  localparam logic [1:0] KIND_DATA = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EXHAUST  = 3'd1;
  localparam logic [2:0] ST_PROTO    = 3'd2;
  localparam logic [2:0] ST_NONE     = 3'd3;
  localparam logic [2:0] ST_RANGE    = 3'd4;

  typedef struct packed {
    logic [2:0]  mode;
    logic [1:0]  msg_kind;
    logic [2:0]  frag_flags;
    logic [31:0] msg_ident;
    logic [15:0] frag_offset;
    logic [15:0] packet_size;
    logic [15:0] frag_length;
    logic [7:0]  new_link_state;
    logic [7:0]  rx_time_count;
    logic [7:0]  rx_control_flags;
    logic [7:0]  data_byte;
    logic [11:0] read_index;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        packet_ready;
    logic [12:0] ready_size;
    logic        ended_with_error;
    logic [7:0]  link_state_out;
    logic [7:0]  read_data;
    logic        tc_valid;
    logic [7:0]  tc_time_count;
    logic [7:0]  tc_control_flags;
    logic [3:0]  tc_queued;
  } out_item_t;

  // fields of a result that wait for memory read data
  typedef struct packed {
    out_item_t   res;
    logic        use_store;
    logic        use_ring;
  } pend_t;

endpackage

// ----- src/frts_stream_if.sv -----
// valid/ready channel carrying one word of a given payload type
// no dependencies; the payload type is a parameter
interface frts_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- src/frts_ram.sv -----
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module frts_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ----- src/frts_ctrl.sv -----
// control path: header checks, assembly state, ring pointers, link state
// depends on frts_pkg; drives the packet store and time-code ring rams
module frts_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            step,
  input  frts_pkg::in_item_t              item,
  output frts_pkg::pend_t                 pend,
  output logic                            st_we,
  output logic [frts_pkg::StoreAw-1:0]    st_waddr,
  output logic                            st_re,
  output logic [frts_pkg::StoreAw-1:0]    st_raddr,
  output logic                            tc_we,
  output logic [frts_pkg::TcAw-1:0]       tc_waddr,
  output logic                            tc_re,
  output logic [frts_pkg::TcAw-1:0]       tc_raddr
);
  localparam int unsigned SW = frts_pkg::SizeW;
  localparam int unsigned AW = frts_pkg::TcAw;
  localparam int unsigned CW = frts_pkg::CntW;

  logic          assembling_r, assembling_nxt;
  logic          held_ready_r, held_ready_nxt;
  logic [31:0]   open_id_r, open_id_nxt;
  logic [SW-1:0] open_total_r, open_total_nxt;
  logic [SW-1:0] next_off_r, next_off_nxt;
  logic          held_eep_r, held_eep_nxt;
  logic [15:0]   pending_r, pending_nxt;
  logic          discarding_r, discarding_nxt;
  logic          finish_r, finish_nxt;
  logic [AW-1:0] tc_head_r, tc_head_nxt;
  logic [CW-1:0] tc_count_r, tc_count_nxt;
  logic [7:0]    link_r, link_nxt;

  logic [2:0]    status;
  logic          start, fin, drop;
  logic [16:0]   room, off_sum;
  logic [AW-1:0] tail;

  assign start   = item.frag_flags[0];
  assign fin     = item.frag_flags[1];
  assign tail    = tc_head_r + tc_count_r[AW-1:0];

  always_comb begin
    assembling_nxt = assembling_r;
    held_ready_nxt = held_ready_r;
    open_id_nxt    = open_id_r;
    open_total_nxt = open_total_r;
    next_off_nxt   = next_off_r;
    held_eep_nxt   = held_eep_r;
    pending_nxt    = pending_r;
    discarding_nxt = discarding_r;
    finish_nxt     = finish_r;
    tc_head_nxt    = tc_head_r;
    tc_count_nxt   = tc_count_r;
    link_nxt       = link_r;
    status         = frts_pkg::ST_OK;
    drop           = 1'b0;
    st_we          = 1'b0;
    st_re          = 1'b0;
    tc_we          = 1'b0;
    tc_re          = 1'b0;
    room           = 17'(open_total_r) - 17'(next_off_r);
    off_sum        = 17'(next_off_r) + 17'(item.frag_length);
    pend.use_store = 1'b0;
    pend.use_ring  = 1'b0;

    unique case (item.mode)
      frts_pkg::MODE_HEADER: begin
        if (pending_r != 16'd0) begin
          if (!discarding_r) drop = 1'b1;
          pending_nxt    = 16'd0;
          discarding_nxt = 1'b0;
          status         = frts_pkg::ST_PROTO;
        end else if (item.msg_kind == frts_pkg::KIND_LINK) begin
          link_nxt = item.new_link_state;
        end else if (item.msg_kind == frts_pkg::KIND_TC) begin
          if (tc_count_r >= CW'(frts_pkg::TcDepth)) begin
            status = frts_pkg::ST_EXHAUST;
          end else begin
            tc_we        = 1'b1;
            tc_count_nxt = tc_count_r + CW'(1);
          end
        end else if (item.msg_kind == frts_pkg::KIND_DATA) begin
          if (held_ready_r) begin
            status         = frts_pkg::ST_EXHAUST;
            pending_nxt    = item.frag_length;
            discarding_nxt = 1'b1;
          end else if (start && (assembling_r || item.frag_offset != 16'd0 ||
                       32'(item.packet_size) > 32'(frts_pkg::MaxPacket))) begin
            status         = frts_pkg::ST_PROTO;
            pending_nxt    = item.frag_length;
            discarding_nxt = 1'b1;
          end else if (!start && (!assembling_r || open_id_r != item.msg_ident ||
                       16'(open_total_r) != item.packet_size ||
                       item.packet_size > 16'(frts_pkg::MaxPacket))) begin
            status         = frts_pkg::ST_PROTO;
            pending_nxt    = item.frag_length;
            discarding_nxt = 1'b1;
          end else begin
            // on a start the window restarts at offset zero
            if (start) begin
              room    = 17'(item.packet_size);
              off_sum = 17'(item.frag_length);
            end
            if (item.frag_offset != (start ? 16'd0 : 16'(next_off_r)) ||
                17'(item.frag_length) > room ||
                (fin && off_sum != 17'(item.packet_size))) begin
              drop           = 1'b1;
              status         = frts_pkg::ST_PROTO;
              pending_nxt    = item.frag_length;
              discarding_nxt = 1'b1;
            end else begin
              assembling_nxt = 1'b1;
              open_id_nxt    = item.msg_ident;
              open_total_nxt = SW'(item.packet_size);
              if (start) next_off_nxt = '0;
              discarding_nxt = 1'b0;
              pending_nxt    = item.frag_length;
              finish_nxt     = fin;
              if (fin) held_eep_nxt = item.frag_flags[2];
              if (fin && item.frag_length == 16'd0) begin
                assembling_nxt = 1'b0;
                held_ready_nxt = 1'b1;
                finish_nxt     = 1'b0;
              end
            end
          end
        end else begin
          status = frts_pkg::ST_PROTO;
        end
      end
      frts_pkg::MODE_PAYLOAD: begin
        if (pending_r == 16'd0) begin
          status = frts_pkg::ST_PROTO;
        end else if (discarding_r) begin
          pending_nxt = pending_r - 16'd1;
          if (pending_r == 16'd1) discarding_nxt = 1'b0;
        end else begin
          st_we        = 1'b1;
          next_off_nxt = next_off_r + SW'(1);
          pending_nxt  = pending_r - 16'd1;
          if (pending_r == 16'd1 && finish_r) begin
            assembling_nxt = 1'b0;
            held_ready_nxt = 1'b1;
            finish_nxt     = 1'b0;
          end
        end
      end
      frts_pkg::MODE_READ: begin
        if (!held_ready_r) begin
          status = frts_pkg::ST_NONE;
        end else if (SW'(item.read_index) >= open_total_r) begin
          status = frts_pkg::ST_RANGE;
        end else begin
          st_re          = 1'b1;
          pend.use_store = 1'b1;
        end
      end
      frts_pkg::MODE_RELEASE: begin
        if (!held_ready_r) status = frts_pkg::ST_NONE;
        else drop = 1'b1;
      end
      frts_pkg::MODE_POP: begin
        if (tc_count_r == '0) begin
          status = frts_pkg::ST_NONE;
        end else begin
          tc_re         = 1'b1;
          pend.use_ring = 1'b1;
          tc_head_nxt   = tc_head_r + AW'(1);
          tc_count_nxt  = tc_count_r - CW'(1);
        end
      end
      frts_pkg::MODE_RESET: begin
        drop           = 1'b1;
        pending_nxt    = 16'd0;
        discarding_nxt = 1'b0;
        tc_head_nxt    = '0;
        tc_count_nxt   = '0;
      end
      default: status = frts_pkg::ST_PROTO;
    endcase

    if (drop) begin
      assembling_nxt = 1'b0;
      held_ready_nxt = 1'b0;
      held_eep_nxt   = 1'b0;
      finish_nxt     = 1'b0;
      open_id_nxt    = '0;
      open_total_nxt = '0;
      next_off_nxt   = '0;
    end

    pend.res.status           = status;
    pend.res.packet_ready     = held_ready_nxt;
    pend.res.ready_size       = held_ready_nxt ? 13'(open_total_nxt) : 13'd0;
    pend.res.ended_with_error = held_ready_nxt & held_eep_nxt;
    pend.res.link_state_out   = link_nxt;
    pend.res.read_data        = 8'd0;
    pend.res.tc_valid         = pend.use_ring;
    pend.res.tc_time_count    = 8'd0;
    pend.res.tc_control_flags = 8'd0;
    pend.res.tc_queued        = 4'(tc_count_nxt);

    // writes past the store end are dropped; every enable is gated by a live step
    st_we    = st_we & step & (next_off_r < SW'(frts_pkg::MaxPacket));
    st_re    = st_re & step;
    tc_we    = tc_we & step;
    tc_re    = tc_re & step;
  end

  assign st_waddr = next_off_r[frts_pkg::StoreAw-1:0];
  assign st_raddr = item.read_index[frts_pkg::StoreAw-1:0];
  assign tc_waddr = tail;
  assign tc_raddr = tc_head_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      assembling_r <= 1'b0;
      held_ready_r <= 1'b0;
      open_id_r    <= '0;
      open_total_r <= '0;
      next_off_r   <= '0;
      held_eep_r   <= 1'b0;
      pending_r    <= '0;
      discarding_r <= 1'b0;
      finish_r     <= 1'b0;
      tc_head_r    <= '0;
      tc_count_r   <= '0;
      link_r       <= '0;
    end else if (step) begin
      assembling_r <= assembling_nxt;
      held_ready_r <= held_ready_nxt;
      open_id_r    <= open_id_nxt;
      open_total_r <= open_total_nxt;
      next_off_r   <= next_off_nxt;
      held_eep_r   <= held_eep_nxt;
      pending_r    <= pending_nxt;
      discarding_r <= discarding_nxt;
      finish_r     <= finish_nxt;
      tc_head_r    <= tc_head_nxt;
      tc_count_r   <= tc_count_nxt;
      link_r       <= link_nxt;
    end
  end
endmodule

// ----- src/frts_out.sv -----
// result stage: merges ram read data into the pending word, with a skid slot
// depends on frts_pkg
module frts_out (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  frts_pkg::pend_t      pend,
  input  logic [7:0]           st_rdata,
  input  logic [15:0]          tc_rdata,
  output logic                 can_take,
  frts_stream_if.source        out
);
  logic            s1_valid_r;
  frts_pkg::pend_t s1_r;
  logic            sk_valid_r;
  frts_pkg::out_item_t sk_r;
  frts_pkg::out_item_t s1_word;

  always_comb begin
    s1_word = s1_r.res;
    if (s1_r.use_store) s1_word.read_data = st_rdata;
    if (s1_r.use_ring) begin
      s1_word.tc_time_count    = tc_rdata[15:8];
      s1_word.tc_control_flags = tc_rdata[7:0];
    end
  end

  // output shows the skid slot first, then the stage that holds ram data
  assign out.valid = sk_valid_r | s1_valid_r;
  assign out.data  = sk_valid_r ? sk_r : s1_word;
  // a new word may enter while the skid slot is free
  assign can_take  = !sk_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      sk_valid_r <= 1'b0;
    end else begin
      if (sk_valid_r) begin
        if (out.ready) begin
          sk_valid_r <= 1'b0;
        end
      end else if (s1_valid_r && !out.ready && step) begin
        sk_valid_r <= 1'b1;
      end
      if (step) begin
        s1_valid_r <= 1'b1;
      end else if (!sk_valid_r && out.ready) begin
        s1_valid_r <= 1'b0;
      end else if (sk_valid_r && out.ready) begin
        s1_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!sk_valid_r && s1_valid_r && !out.ready && step) begin
      sk_r <= s1_word;
    end
    if (step) begin
      s1_r <= pend;
    end
  end
endmodule

// ----- src/fragment_reassembler_with_timecode_queue_unit.sv -----
// top level of the fragment reassembler with time-code queue
// depends on frts_pkg, frts_stream_if, frts_ram, frts_ctrl, frts_out
//
// in: one word per operation (header, payload byte, read, release, pop,
//   receiver reset); every accepted word yields exactly one out word
// out: status, held packet info, link state, read byte, popped time code
// the result is registered in the output stage, alongside the packet
//   store and time-code ring reads
// throughput: one word per cycle unless stalled; state lives in two
//   rams (4096 x 8 packet store, 8 x 16 time-code ring) plus control
//   flops, updated on accept so back-to-back words see fresh state
// a stalled receiver parks the finished word in a skid slot; in stays
//   ready until that slot is full, then waits for the receiver
// reset (rst_n low, synchronous) clears all control state; the rams keep
//   their contents and are never read before being written
// the link state register resets to zero (error reset)
module fragment_reassembler_with_timecode_queue_unit (
  input  logic          clk,
  input  logic          rst_n,
  frts_stream_if.sink   in,
  frts_stream_if.source out
);
  logic                          step, can_take;
  frts_pkg::pend_t               pend;
  logic                          st_we, st_re, tc_we, tc_re;
  logic [frts_pkg::StoreAw-1:0]  st_waddr, st_raddr;
  logic [frts_pkg::TcAw-1:0]     tc_waddr, tc_raddr;
  logic [7:0]                    st_rdata;
  logic [15:0]                   tc_rdata;
  frts_pkg::in_item_t            item;

  assign item     = in.data;
  assign in.ready = can_take;
  assign step     = in.valid & can_take;

  frts_ctrl u_ctrl (
    .clk, .rst_n, .step, .item, .pend,
    .st_we, .st_waddr, .st_re, .st_raddr,
    .tc_we, .tc_waddr, .tc_re, .tc_raddr
  );

  frts_ram #(.Width(8), .Depth(frts_pkg::MaxPacket)) u_store (
    .clk, .we(st_we), .waddr(st_waddr), .wdata(item.data_byte),
    .re(st_re), .raddr(st_raddr), .rdata(st_rdata)
  );

  frts_ram #(.Width(16), .Depth(frts_pkg::TcDepth)) u_ring (
    .clk, .we(tc_we), .waddr(tc_waddr),
    .wdata({item.rx_time_count, item.rx_control_flags}),
    .re(tc_re), .raddr(tc_raddr), .rdata(tc_rdata)
  );

  frts_out u_out (
    .clk, .rst_n, .step, .pend, .st_rdata, .tc_rdata, .can_take, .out
  );
endmodule

// ----- src/frts_checker.sv -----
// port-level checks for the reassembler top level, attached by bind
// depends on frts_pkg
module frts_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input frts_pkg::out_item_t out_data,
  input logic                out_valid,
  input logic                out_rdy
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_rdy |=> out_valid && $stable(out_data))
    else $error("out word changed while stalled");

  a_ready_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.packet_ready |-> out_data.ready_size == 13'd0 &&
      !out_data.ended_with_error)
    else $error("size shown without a held packet");

  a_tc_depth: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.tc_queued <= 4'(frts_pkg::TcDepth))
    else $error("time-code count past ring depth");

  a_word_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted word produced no result");
endmodule

bind fragment_reassembler_with_timecode_queue_unit frts_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in.valid), .in_ready(in.ready),
  .out_data(out.data), .out_valid(out.valid), .out_rdy(out.ready)
);
